// ===== rtl/core/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg
// Shared sizes, codes, types and helpers of the buddy allocator tree.
// ----------------------------------------------------------------------------
package bat_pkg;

    // Region and tree geometry
    localparam int TOTAL_EXP  = 16;
    localparam int BLOCK_EXP  = 6;
    localparam int LEVELS     = TOTAL_EXP - BLOCK_EXP;
    localparam int NODE_W     = LEVELS + 1;
    localparam int LEAF_FIRST = (1 << LEVELS) - 1;

    // Sibling-pair memory: word p holds both children of node p
    localparam int EXP_W      = 5;
    localparam int PAIR_W     = 2 * EXP_W;
    localparam int PAIR_DEPTH = (1 << LEVELS) - 1;
    localparam int PAIR_AW    = LEVELS;

    // Field widths
    localparam int ADDR_W     = 48;
    localparam int BYTES_W    = 17;
    localparam int USED_W     = 17;
    localparam int STATUS_W   = 2;

    // Stream widths
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 2;

    // Register port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = '0;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_MEM  = 2'd1,
        STATUS_IGNORED = 2'd2,
        STATUS_UNALLOC = 2'd3
    } status_t;

    // Operands of the shared node unit
    typedef struct packed {
        logic [PAIR_W-1:0] pair;     // {right, left} child exponents
        logic              is_left;  // current node is the left child
        logic [EXP_W-1:0]  new_val;  // value to store into the current node
        logic [EXP_W-1:0]  size;     // level exponent of the current node
        logic [EXP_W-1:0]  need;     // exponent wanted by an allocate
    } node_op_t;

    typedef struct packed {
        logic [EXP_W-1:0]  own_val;    // stored value of the current node
        logic [PAIR_W-1:0] new_pair;   // pair word with the current node replaced
        logic [EXP_W-1:0]  parent_val; // parent value after merge
        logic              go_left;    // left child can hold the request
    } node_res_t;

    function automatic logic [EXP_W-1:0] bit_length(input logic [BYTES_W-1:0] v);
        logic [EXP_W-1:0] n;
        n = '0;
        for (int k = 0; k < BYTES_W; k++) begin
            if (v[k]) begin
                n = EXP_W'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [NODE_W-1:0] parent_of(input logic [NODE_W-1:0] i);
        return (i - NODE_W'(1)) >> 1;
    endfunction

endpackage

// ===== rtl/core/bat_ram.sv =====
// ----------------------------------------------------------------------------
// bat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/bat_node_unit.sv =====
// ----------------------------------------------------------------------------
// bat_node_unit
// Shared compare and merge unit applied to one sibling-pair word per step.
// ----------------------------------------------------------------------------
module bat_node_unit
    import bat_pkg::*;
(
    input  node_op_t  op,
    output node_res_t res
);

    logic [EXP_W-1:0] left_old;
    logic [EXP_W-1:0] right_old;
    logic [EXP_W-1:0] left_new;
    logic [EXP_W-1:0] right_new;

    always_comb begin
        left_old  = op.pair[EXP_W-1:0];
        right_old = op.pair[PAIR_W-1:EXP_W];
        left_new  = op.is_left ? op.new_val : left_old;
        right_new = op.is_left ? right_old : op.new_val;

        res.own_val  = op.is_left ? left_old : right_old;
        res.new_pair = {right_new, left_new};
        res.go_left  = (left_old >= op.need);

        // two fully free buddies merge into one block of the parent's size
        if ((left_new == op.size) && (right_new == op.size)) begin
            res.parent_val = op.size + EXP_W'(1);
        end else begin
            res.parent_val = (left_new > right_new) ? left_new : right_new;
        end
    end

endmodule

// ===== rtl/core/bat_apb_regs.sv =====
// ----------------------------------------------------------------------------
// bat_apb_regs
// Register port holding the base address of the managed region.
// ----------------------------------------------------------------------------
module bat_apb_regs
    import bat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ADDR_W-1:0]     base_address
);

    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    base_next;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
    assign pready  = 1'b1;

    always_comb begin
        base_next = base_reg;
        if (psel && penable && pwrite && (reg_idx == REG_BASE_ADDRESS)) begin
            base_next = pwdata[ADDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_BASE_ADDRESS) begin
            prdata = CFG_DATA_W'(base_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else begin
            base_reg <= base_next;
        end
    end

    assign base_address = base_reg;

endmodule

// ===== rtl/core/buddy_allocator_tree_top.sv =====
// ----------------------------------------------------------------------------
// buddy_allocator_tree_top
// Binary buddy allocator over a complete tree of free-block exponents.
// ----------------------------------------------------------------------------
// One request is taken at a time. After reset the block sweeps its node
// memory (one sibling-pair word per cycle) and is not ready during that
// sweep; register writes are taken as ever. An allocate walks down with
// one RAM access per tree level, then walks back up with one access per
// level to refresh the ancestors. A free makes one access per level
// climbing from the leaf to the taken node, then one per level merging
// buddies up to the root; a free of an in-region address that is not
// handed out climbs all the way to the root. Rejected requests (zero size,
// null pointer, no space, address outside the region) go straight to the
// result without touching the tree. The single node RAM port pair and the
// shared compare/merge unit set this one-access-per-level pace. A finished
// result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module buddy_allocator_tree_top
    import bat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // request_bytes[16:0], free_address[64:17]
    input  logic [S_TUSER_W-1:0]  s_tuser,  // func[0], free_is_null[1]

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // block_address[47:0], bytes_in_use[64:48]
    output logic [M_TUSER_W-1:0]  m_tuser,  // status[1:0]

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_START = 7'b0000100,
        ST_DOWN  = 7'b0001000,
        ST_CLIMB = 7'b0010000,
        ST_UP    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // control state
    state_t              state_reg,     state_next;
    logic [PAIR_AW-1:0]  init_addr_reg, init_addr_next;
    logic [EXP_W-1:0]    init_exp_reg,  init_exp_next;
    logic [EXP_W-1:0]    root_reg,      root_next;
    logic [USED_W-1:0]   used_reg,      used_next;
    logic                m_tvalid_reg,  m_tvalid_next;

    // request and walk payload
    logic                func_reg,      func_next;
    logic [BYTES_W-1:0]  bytes_reg,     bytes_next;
    logic [ADDR_W-1:0]   faddr_reg,     faddr_next;
    logic                null_reg,      null_next;
    logic [EXP_W-1:0]    need_reg,      need_next;
    logic [NODE_W-1:0]   node_reg,      node_next;
    logic [EXP_W-1:0]    size_reg,      size_next;
    logic [EXP_W-1:0]    val_reg,       val_next;
    logic [TOTAL_EXP-1:0] offset_reg,   offset_next;
    status_t             status_reg,    status_next;
    logic                grant_reg,     grant_next;

    // result payload
    logic [ADDR_W-1:0]   m_addr_reg,    m_addr_next;
    status_t             m_status_reg,  m_status_next;
    logic [USED_W-1:0]   m_used_reg,    m_used_next;

    // node memory
    logic                ram_we;
    logic [PAIR_AW-1:0]  ram_waddr;
    logic [PAIR_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [PAIR_AW-1:0]  ram_raddr;
    logic [PAIR_W-1:0]   ram_rdata;

    node_op_t            nu_op;
    node_res_t           nu_res;

    logic [ADDR_W-1:0]   base_address;

    // per-step helpers
    logic [EXP_W-1:0]    blen_c;
    logic [EXP_W-1:0]    need_c;
    logic [ADDR_W-1:0]   diff_c;
    logic [NODE_W-1:0]   leaf_c;
    logic [NODE_W-1:0]   leaf_par_c;
    logic [NODE_W-1:0]   par_c;
    logic [NODE_W-1:0]   gpar_c;
    logic [NODE_W-1:0]   child_c;
    logic [EXP_W-1:0]    csize_c;
    logic [EXP_W-1:0]    own_c;
    logic [NODE_W-1:0]   init_p1;
    logic [NODE_W-1:0]   init_p2;

    bat_apb_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_address (base_address)
    );

    bat_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (PAIR_DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The shared unit always looks at the pair word just read and the node
    // under the walk pointer; each state uses the part of the answer it needs.
    assign nu_op.pair    = ram_rdata;
    assign nu_op.is_left = node_reg[0];
    assign nu_op.new_val = val_reg;
    assign nu_op.size    = size_reg;
    assign nu_op.need    = need_reg;

    bat_node_unit u_node_unit (
        .op  (nu_op),
        .res (nu_res)
    );

    always_comb begin
        // round the request up to a power of two, at least one block
        blen_c     = bit_length(bytes_reg - BYTES_W'(1));
        need_c     = (blen_c < EXP_W'(BLOCK_EXP)) ? EXP_W'(BLOCK_EXP) : blen_c;
        diff_c     = faddr_reg - base_address;
        leaf_c     = NODE_W'(LEAF_FIRST) + NODE_W'(diff_c[TOTAL_EXP-1:BLOCK_EXP]);
        leaf_par_c = parent_of(leaf_c);
        par_c      = parent_of(node_reg);
        gpar_c     = parent_of(par_c);
        csize_c    = size_reg - EXP_W'(1);
        child_c    = nu_res.go_left ? ((node_reg << 1) + NODE_W'(1))
                                    : ((node_reg << 1) + NODE_W'(2));
        own_c      = (node_reg == '0) ? root_reg : nu_res.own_val;
        init_p1    = NODE_W'(init_addr_reg) + NODE_W'(1);
        init_p2    = NODE_W'(init_addr_reg) + NODE_W'(2);
    end

    always_comb begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        init_exp_next  = init_exp_reg;
        root_next      = root_reg;
        used_next      = used_reg;
        m_tvalid_next  = m_tvalid_reg;
        func_next      = func_reg;
        bytes_next     = bytes_reg;
        faddr_next     = faddr_reg;
        null_next      = null_reg;
        need_next      = need_reg;
        node_next      = node_reg;
        size_next      = size_reg;
        val_next       = val_reg;
        offset_next    = offset_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        m_addr_next    = m_addr_reg;
        m_status_next  = m_status_reg;
        m_used_next    = m_used_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // drop the result once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                // fill each pair word with its children's level exponent
                ram_we         = 1'b1;
                ram_waddr      = init_addr_reg;
                ram_wdata      = {init_exp_reg, init_exp_reg};
                init_addr_next = init_addr_reg + PAIR_AW'(1);
                if ((init_p1 & init_p2) == '0) begin
                    init_exp_next = init_exp_reg - EXP_W'(1);
                end
                if (init_addr_reg == PAIR_AW'(PAIR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser[0];
                    null_next  = s_tuser[1];
                    bytes_next = s_tdata[BYTES_W-1:0];
                    faddr_next = s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
                    state_next = ST_START;
                end
            end

            ST_START: begin
                grant_next  = 1'b0;
                offset_next = '0;
                state_next  = ST_DONE;
                if (func_reg == FUNC_ALLOC) begin
                    if (bytes_reg == '0) begin
                        status_next = STATUS_IGNORED;
                    end else if (root_reg < need_c) begin
                        status_next = STATUS_NO_MEM;
                    end else if (need_c == EXP_W'(TOTAL_EXP)) begin
                        // whole region in one block: take the root
                        root_next   = '0;
                        used_next   = used_reg + (USED_W'(1) << need_c);
                        status_next = STATUS_OK;
                        grant_next  = 1'b1;
                    end else begin
                        need_next  = need_c;
                        node_next  = '0;
                        size_next  = EXP_W'(TOTAL_EXP);
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_DOWN;
                    end
                end else begin
                    if (null_reg) begin
                        status_next = STATUS_IGNORED;
                    end else if (diff_c[ADDR_W-1:TOTAL_EXP] != '0) begin
                        status_next = STATUS_UNALLOC;
                    end else begin
                        node_next  = leaf_c;
                        size_next  = EXP_W'(BLOCK_EXP);
                        ram_re     = 1'b1;
                        ram_raddr  = leaf_par_c[PAIR_AW-1:0];
                        state_next = ST_CLIMB;
                    end
                end
            end

            ST_DOWN: begin
                // step into the left child if it can hold the request
                node_next = child_c;
                size_next = csize_c;
                if (!nu_res.go_left) begin
                    offset_next = offset_reg | (TOTAL_EXP'(1) << csize_c);
                end
                if (csize_c == need_reg) begin
                    // hold the pair word; the ascent starts from it
                    val_next   = '0;
                    used_next  = used_reg + (USED_W'(1) << csize_c);
                    state_next = ST_UP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = child_c[PAIR_AW-1:0];
                end
            end

            ST_CLIMB: begin
                if (own_c == '0) begin
                    // taken block found: release it
                    used_next = used_reg - (USED_W'(1) << size_reg);
                    if (node_reg == '0) begin
                        root_next   = size_reg;
                        status_next = STATUS_OK;
                        state_next  = ST_DONE;
                    end else begin
                        val_next   = size_reg;
                        state_next = ST_UP;
                    end
                end else if (node_reg == '0) begin
                    status_next = STATUS_UNALLOC;
                    state_next  = ST_DONE;
                end else begin
                    node_next = par_c;
                    size_next = size_reg + EXP_W'(1);
                    if (par_c != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = gpar_c[PAIR_AW-1:0];
                    end
                end
            end

            ST_UP: begin
                // write the new node value into its pair, push the merge upward
                ram_we    = 1'b1;
                ram_waddr = par_c[PAIR_AW-1:0];
                ram_wdata = nu_res.new_pair;
                if (par_c == '0) begin
                    root_next   = nu_res.parent_val;
                    status_next = STATUS_OK;
                    grant_next  = (func_reg == FUNC_ALLOC);
                    state_next  = ST_DONE;
                end else begin
                    node_next = par_c;
                    val_next  = nu_res.parent_val;
                    size_next = size_reg + EXP_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = gpar_c[PAIR_AW-1:0];
                end
            end

            ST_DONE: begin
                // advance once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = grant_reg ? (base_address + ADDR_W'(offset_reg)) : '0;
                    m_status_next = status_reg;
                    m_used_next   = used_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            init_exp_reg  <= EXP_W'(TOTAL_EXP - 1);
            root_reg      <= EXP_W'(TOTAL_EXP);
            used_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            init_exp_reg  <= init_exp_next;
            root_reg      <= root_next;
            used_reg      <= used_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        bytes_reg    <= bytes_next;
        faddr_reg    <= faddr_next;
        null_reg     <= null_next;
        need_reg     <= need_next;
        node_reg     <= node_next;
        size_reg     <= size_next;
        val_reg      <= val_next;
        offset_reg   <= offset_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
        m_used_reg   <= m_used_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - USED_W - ADDR_W){1'b0}}, m_used_reg, m_addr_reg};
    assign m_tuser  = M_TUSER_W'(m_status_reg);

    // no request is taken while the node memory is being swept
    a_init_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !s_tready)
        else $error("request taken during node memory sweep");

    // the tree never changes while no request is in flight
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("node memory written while idle");

    // the root never advertises more than the whole region
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        root_reg <= EXP_W'(TOTAL_EXP))
        else $error("root exponent above region size");

    // a full tree between requests means every byte is handed out
    a_full_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && (root_reg == '0)) |-> (used_reg == (USED_W'(1) << TOTAL_EXP)))
        else $error("bytes in use disagree with a full tree");

    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (used_reg <= (USED_W'(1) << TOTAL_EXP)))
        else $error("bytes in use above region size");

endmodule
